// ===== src/qtp_pkg.sv =====
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared widths, defaults and register codes of the 2x2 texel block packer.
// ----------------------------------------------------------------------------
package qtp_pkg;

    // Payload widths.
    localparam int TEXEL_W = 8;
    localparam int WORD_W  = 32;

    // Configuration port widths.
    localparam int DIM_W       = 11;
    localparam int CFG_INDEX_W = 2;

    // Default image size limits.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

endpackage

// ===== src/qtp_intf.sv =====
// ----------------------------------------------------------------------------
// qtp_intf
// Valid/ready channels of the texel packer: the texel stream in and the
// packed block words out.
// ----------------------------------------------------------------------------
interface qtp_texel_if;
    import qtp_pkg::*;

    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] texel;

    modport source (output valid, output texel, input ready);
    modport sink   (input valid, input texel, output ready);
endinterface

interface qtp_word_if;
    import qtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;
    logic              last_word;

    modport source (output valid, output packed_word, output last_word, input ready);
    modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

// ===== src/qtp_line_store.sv =====
// ----------------------------------------------------------------------------
// qtp_line_store
// Single-port-write, single-port-read line memory with a registered read.
// ----------------------------------------------------------------------------
module qtp_line_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/quad_texel_packer.sv =====
// ----------------------------------------------------------------------------
// quad_texel_packer
// Packs a raster stream of 8-bit texels into one 32-bit word per 2x2 block.
// ----------------------------------------------------------------------------
// Usage:
// Texels enter on in_if in raster order, one per transaction. Each 2x2 block
// leaves on out_if as one word (top-left in bits 7:0, top-right 15:8,
// bottom-left 23:16, bottom-right 31:24), with last_word set on the final
// word of the image. Width and height are written on the cfg port while the
// block is idle; a write to either size register restarts the image at its
// top-left texel. Throughput is one texel per cycle while out_if is not
// stalled. A word is produced on the bottom-right texel of its block (on the
// last row of an odd-height image, on the top texel itself) and reaches
// out_if through the registered read of the pair-wide line store holding
// the even row, then the output register.
// Reset sets the size to 1x1 and both counters to zero; the line store is
// not cleared, since an odd row only reads entries the even row above it
// has just written.
// When the receiver stalls, up to two words are held (read stage and output
// register) and in_if.ready then drops until the output drains.
// ----------------------------------------------------------------------------
module quad_texel_packer #(
    parameter int MAX_WIDTH  = qtp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = qtp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [qtp_pkg::DIM_W-1:0]       cfg_data,
    qtp_texel_if.sink                       in_if,
    qtp_word_if.source                      out_if
);
    import qtp_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int PAIRS = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int PW    = 2 * TEXEL_W;

    // Clamp a register value to 1..maxv and return that value minus one.
    function automatic logic [31:0] dim_last(input logic [DIM_W-1:0] v,
                                             input int unsigned maxv);
        logic [31:0] v32;
        begin
            v32 = 32'(v);
            if (v32 == 32'd0)
                return 32'd0;
            else if (v32 > maxv)
                return maxv - 1;
            else
                return v32 - 32'd1;
        end
    endfunction

    // Size registers (last column and last row indexes) and counters.
    logic [XW-1:0]      wlast_reg, wlast_next;
    logic [YW-1:0]      hlast_reg, hlast_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [TEXEL_W-1:0] prev_reg;

    // Read stage and output register.
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic               s1_from_mem_reg;
    logic               s1_dup_reg;
    logic [WORD_W-1:0]  s1_word_reg;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg;
    logic               out_last_reg;

    logic               accept;
    logic               out_free;
    logic               s1_move;
    logic               cfg_hit;
    logic               last_col;
    logic               last_row;
    logic               odd_x;
    logic               even_row;
    logic               emit;
    logic [TEXEL_W-1:0] t;
    logic [WORD_W-1:0]  word_in;
    logic               st_wr_en;
    logic [PW-1:0]      st_wr_data;
    logic               st_rd_en;
    logic [AW-1:0]      st_addr;
    logic [PW-1:0]      st_rd_data;
    logic [PW-1:0]      top_pair;

    // Handshake.
    assign out_free     = !out_valid_reg || out_if.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign in_if.ready  = !s1_valid_reg || out_free;
    assign accept       = in_if.valid && in_if.ready;

    // Position decode of the incoming texel.
    assign t        = in_if.texel;
    assign last_col = (x_reg == wlast_reg);
    assign last_row = (y_reg == hlast_reg);
    assign odd_x    = x_reg[0];
    assign even_row = !y_reg[0];
    assign emit     = even_row ? (last_row && (odd_x || last_col)) : (odd_x || last_col);

    // The even row is stored as pairs {right, left}; an odd last column
    // stores its texel in both halves.
    assign st_addr    = AW'(x_reg >> 1);
    assign st_wr_en   = accept && even_row && (odd_x || last_col);
    assign st_wr_data = odd_x ? {t, prev_reg} : {t, t};
    assign st_rd_en   = accept && !even_row && emit;

    qtp_line_store #(
        .DEPTH (PAIRS),
        .AW    (AW),
        .DW    (PW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_addr),
        .rd_data (st_rd_data)
    );

    // Word known at the input: complete on an even row, bottom half only on
    // an odd row, where the top half comes from the line store.
    always_comb
    begin
        if (even_row && odd_x)
            word_in = {t, prev_reg, t, prev_reg};
        else if (even_row)
            word_in = {t, t, t, t};
        else if (odd_x)
            word_in = {t, prev_reg, {PW{1'b0}}};
        else
            word_in = {t, t, {PW{1'b0}}};
    end

    // Configuration decode.
    always_comb
    begin
        cfg_hit    = 1'b0;
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    cfg_hit    = 1'b1;
                    wlast_next = XW'(dim_last(cfg_data, MAX_WIDTH));
                end
                CFG_IMAGE_HEIGHT:
                begin
                    cfg_hit    = 1'b1;
                    hlast_next = YW'(dim_last(cfg_data, MAX_HEIGHT));
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Raster counters; a register write restarts the image.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        priority if (cfg_hit)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                x_next = '0;
                y_next = last_row ? '0 : y_reg + YW'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
        else
        begin
            x_next = x_reg;
            y_next = y_reg;
        end
    end

    // Pipeline valid flags.
    always_comb
    begin
        if (accept)
            s1_valid_next = emit;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_move)
            out_valid_next = 1'b1;
        else if (out_if.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Top half of the word in the read stage.
    always_comb
    begin
        if (!s1_from_mem_reg)
            top_pair = s1_word_reg[PW-1:0];
        else if (s1_dup_reg)
            top_pair = {st_rd_data[TEXEL_W-1:0], st_rd_data[TEXEL_W-1:0]};
        else
            top_pair = st_rd_data;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg     <= '0;
            hlast_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            prev_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlast_reg     <= wlast_next;
            hlast_reg     <= hlast_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                prev_reg <= t;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg     <= word_in;
            s1_last_reg     <= last_col && last_row;
            s1_from_mem_reg <= !even_row;
            s1_dup_reg      <= !odd_x;
        end
        if (s1_move)
        begin
            out_word_reg <= {s1_word_reg[WORD_W-1:PW], top_pair};
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_if.valid       = out_valid_reg;
    assign out_if.packed_word = out_word_reg;
    assign out_if.last_word   = out_last_reg;

endmodule

// ===== src/qtp_checker.sv =====
// ----------------------------------------------------------------------------
// qtp_checker
// Port-level checks of the texel packer, bound to its top level.
// ----------------------------------------------------------------------------
module qtp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [qtp_pkg::WORD_W-1:0] out_word,
    input logic                       out_last
);
    import qtp_pkg::*;

    // A word waiting for the receiver stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("qtp: output transaction withdrawn while stalled");

    // A stalled word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
        else $error("qtp: output payload changed while stalled");

    // Nothing is offered in the first cycle after reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("qtp: output valid straight after reset");

    // An empty output fills only from an accepted texel that has passed the read stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 2) && $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("qtp: output word without a matching input transaction");

endmodule

bind quad_texel_packer qtp_checker u_qtp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_if.packed_word),
    .out_last  (out_if.last_word)
);

// ===== verif/tb_quad_texel_packer.sv =====
// ----------------------------------------------------------------------------
// tb_quad_texel_packer
// Self-checking bench for the 2x2 texel block packer. Texels come from a queue
// that the stimulus process fills, and a clocked driver feeds them in with
// random gaps. A predictor follows every accepted texel and keeps the block
// words that ought to appear. A clocked monitor stalls the output at random and
// compares each word and its last flag with the oldest awaited word. The
// image size is changed only while the packer is idle. The run covers a
// directed set of corner cases, then random images, some of them cut short,
// and finally two short runs at oversized register values.
// ----------------------------------------------------------------------------
module tb_quad_texel_packer;
    import qtp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CLAMP_ITEMS   = 40;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // Register indexes that lie beyond the register list.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } block_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    qtp_texel_if texel_ch ();
    qtp_word_if  word_ch ();

    quad_texel_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_if     (texel_ch),
        .out_if    (word_ch)
    );

    // Stimulus and checking state.
    logic [TEXEL_W-1:0] texels_to_send [$];
    block_word_t        awaited_words [$];
    int                 texel_gap;
    int                 word_gap;
    int                 in_gap_max;
    int                 out_gap_max;
    int                 mismatch_count;
    int                 cycle_count;

    // Predictor state: the even-row store, the texel before, the position of
    // the next texel and the two size registers as last written.
    logic [TEXEL_W-1:0] row_store [MAX_W];
    logic [TEXEL_W-1:0] prev_texel;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
        if (v == '0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int draw_gap(input int max_gap);
        return $urandom_range(0, max_gap);
    endfunction

    // Idle limit for one phase: none, short or full length.
    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 19;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Follows one accepted texel and queues the block word it completes, if any.
    task automatic predict_block_word(input logic [TEXEL_W-1:0] t);
        int unsigned       w;
        int unsigned       h;
        int unsigned       x;
        int unsigned       y;
        bit                last_col;
        bit                last_row;
        bit                emit;
        logic [WORD_W-1:0] word;
        block_word_t       item;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        x = col_pos;
        y = row_pos;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);
        emit = 1'b0;
        word = '0;

        if (y % 2 == 0)
        begin
            row_store[x] = t;
            // A lone last row pairs with itself and is emitted at once.
            if (last_row)
            begin
                if (x % 2 == 1)
                begin
                    word = {t, prev_texel, t, prev_texel};
                    emit = 1'b1;
                end
                else if (last_col)
                begin
                    word = {t, t, t, t};
                    emit = 1'b1;
                end
            end
        end
        else
        begin
            if (x % 2 == 1)
            begin
                word = {t, prev_texel, row_store[x], row_store[x-1]};
                emit = 1'b1;
            end
            else if (last_col)
            begin
                // Odd width: the right column repeats the left one.
                word = {t, t, row_store[x], row_store[x]};
                emit = 1'b1;
            end
        end
        prev_texel = t;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
        end

        if (emit)
        begin
            item.word = word;
            item.last = last_col && last_row;
            awaited_words.push_back(item);
        end
    endtask

    task automatic check_word(input logic [WORD_W-1:0] word, input logic last);
        block_word_t want;
        if (awaited_words.size() == 0)
        begin
            report_mismatch($sformatf("word %08h arrived with none awaited", word));
        end
        else
        begin
            want = awaited_words.pop_front();
            if (word !== want.word)
                report_mismatch($sformatf("packed_word %08h, awaited %08h", word, want.word));
            if (last !== want.last)
                report_mismatch($sformatf("last_word %b, awaited %b on word %08h",
                                          last, want.last, want.word));
        end
    endtask

    // Texel driver: one transaction per item, with a drawn idle gap before it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            texel_ch.valid <= 1'b0;
            texel_gap = 0;
        end
        else
        begin
            if (texel_ch.valid && texel_ch.ready)
            begin
                predict_block_word(texel_ch.texel);
                texel_gap = draw_gap(in_gap_max);
            end
            if (!texel_ch.valid || texel_ch.ready)
            begin
                if (texels_to_send.size() == 0)
                begin
                    texel_ch.valid <= 1'b0;
                end
                else if (texel_gap > 0)
                begin
                    texel_gap--;
                    texel_ch.valid <= 1'b0;
                end
                else
                begin
                    texel_ch.texel <= texels_to_send.pop_front();
                    texel_ch.valid <= 1'b1;
                end
            end
        end
    end

    // Word monitor: stalls for a randomly drawn gap before each word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            word_ch.ready <= 1'b0;
            word_gap = 0;
        end
        else
        begin
            if (word_ch.valid && word_ch.ready)
            begin
                check_word(word_ch.packed_word, word_ch.last_word);
                word_gap = draw_gap(out_gap_max);
            end
            if (word_gap > 0)
            begin
                if (word_ch.valid)
                    word_gap--;
                word_ch.ready <= 1'b0;
            end
            else
            begin
                word_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Waits until every texel is sent and every awaited word has arrived,
    // then lets the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        while (texels_to_send.size() != 0 || texel_ch.valid || awaited_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write; the predictor follows it at once, as nothing is in flight.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_IMAGE_WIDTH:
            begin
                width_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IMAGE_HEIGHT:
            begin
                height_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic push_random_texels(input int unsigned n);
        repeat (n) texels_to_send.push_back(TEXEL_W'($urandom_range(0, 255)));
    endtask

    // Stimulus.
    initial
    begin
        int          sent;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned total;
        int unsigned cut;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_IMAGE_WIDTH;
        cfg_data       = '0;
        texel_ch.valid = 1'b0;
        texel_ch.texel = '0;
        word_ch.ready  = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        in_gap_max     = 19;
        out_gap_max    = 19;
        foreach (row_store[i])
            row_store[i] = '0;
        prev_texel = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = 1;
        height_reg = 1;
        sent       = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Size after reset is 1x1: every texel is a whole final block.
        texels_to_send.push_back(8'h00);
        texels_to_send.push_back(8'hFF);
        texels_to_send.push_back(8'h5A);

        // Zero sizes behave as 1x1.
        set_size(0, 0);
        texels_to_send.push_back(8'hC3);
        texels_to_send.push_back(8'h3C);

        // Odd width and odd height together.
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            texels_to_send.push_back(8'(i * 37 + 1));

        set_size(2, 2);
        texels_to_send.push_back(8'hFF);
        texels_to_send.push_back(8'h00);
        texels_to_send.push_back(8'h00);
        texels_to_send.push_back(8'hFF);

        // Writes beyond the register list must not restart the image.
        set_size(4, 2);
        push_random_texels(4);
        wait_idle();
        cfg_write(CFG_SPARE_A, 11'h7FF);
        cfg_write(CFG_SPARE_B, 11'h000);
        push_random_texels(4);

        // Random images, mostly whole, some cut short or paused mid-way.
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            in_gap_max  = pick_gap_max();
            out_gap_max = pick_gap_max();
            case ($urandom_range(0, 9))
                0:       w_val = 0;
                1:       w_val = $urandom_range(13, 40);
                default: w_val = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h_val = 0;
                1:       h_val = $urandom_range(7, 10);
                default: h_val = $urandom_range(1, 6);
            endcase
            set_size(DIM_W'(w_val), DIM_W'(h_val));
            total = clamp_dim(DIM_W'(w_val), MAX_W) * clamp_dim(DIM_W'(h_val), MAX_H)
                    * $urandom_range(1, 3);
            // The last image is cut to keep the item count near its target.
            if (sent + total > RANDOM_ITEMS)
                total = RANDOM_ITEMS - sent;
            if ($urandom_range(0, 5) == 0)
            begin
                // Broken image: the next size write abandons it.
                cut = $urandom_range(1, total);
                push_random_texels(cut);
                sent += cut;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, total);
                push_random_texels(cut);
                wait_idle();
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          DIM_W'($urandom_range(0, 2047)));
                push_random_texels(total - cut);
                sent += total;
            end
            else
            begin
                push_random_texels(total);
                sent += total;
            end
        end

        // Oversized width, clamped to the maximum, on a single row.
        in_gap_max  = 3;
        out_gap_max = 3;
        set_size(11'h7FF, 1);
        push_random_texels(CLAMP_ITEMS);

        // Oversized height, clamped to the maximum, one texel wide.
        set_size(1, 11'h7FF);
        push_random_texels(CLAMP_ITEMS);

        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qtp_pkg.sv
src/qtp_intf.sv
src/qtp_line_store.sv
src/quad_texel_packer.sv
src/qtp_checker.sv
verif/tb_quad_texel_packer.sv
